// File: rtl/weighted_tag_best_match_assert.svh
// ---------------------------------------------------------------------------
// weighted_tag_best_match_assert.svh
// Assertion macros shared by the checker of the weighted tag best-match block.
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_TAG_BEST_MATCH_ASSERT_SVH
`define WEIGHTED_TAG_BEST_MATCH_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define WTBM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wtbm assertion failed");

// Next-cycle implication, reset handled by the caller's antecedent
`define WTBM_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("wtbm assertion failed");

`endif

// File: rtl/wtbm_pkg.sv
// ---------------------------------------------------------------------------
// wtbm_pkg
// Shared widths, constants and types of the weighted tag best-match block.
// ---------------------------------------------------------------------------
package wtbm_pkg;

    localparam int IDX_W       = 12;
    localparam int TAG_W       = 2;
    localparam int VAL_W       = 32;
    localparam int WEIGHT_W    = 32;
    localparam int PERIOD_W    = 40;
    localparam int DIST_W      = 32;
    localparam int PROD_W      = 64;
    localparam int TOTAL_W     = 48;
    localparam int FRAC_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;

    // 1000000.0 in unsigned Q24.16
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 40'd65536000000;

    localparam int ENTRY_DEPTH_DEF = 4096;
    localparam int TAG_KINDS_DEF   = 4;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD_ZERO  = 2'd0,
        CFG_PERIOD_ONE   = 2'd1,
        CFG_PERIOD_TWO   = 2'd2,
        CFG_PERIOD_THREE = 2'd3
    } t_cfg_reg;

    // Classified element handed from the front to the back
    typedef struct packed {
        logic [IDX_W-1:0]    entry;
        logic [IDX_W-1:0]    quot;
        logic [DIST_W-1:0]   min_dist;
        logic [WEIGHT_W-1:0] weight;
        logic                last_entry;
        logic                last_search;
    } t_elem;

endpackage

// File: rtl/wtbm_front.sv
// ---------------------------------------------------------------------------
// wtbm_front
// Holds the tag periods, accepts elements, forms the smaller of the plain and
// wrapped distance and the entry quotient, and pushes the element to the queue.
// ---------------------------------------------------------------------------
module wtbm_front import wtbm_pkg::*; #(
    parameter int ENTRY_DEPTH = ENTRY_DEPTH_DEF,
    parameter int TAG_KINDS   = TAG_KINDS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PERIOD_W-1:0]  i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [IDX_W-1:0]     i_entry_index,
    input  logic [TAG_W-1:0]     i_tag_id,
    input  logic                 i_tag_present,
    input  logic signed [VAL_W-1:0] i_stored_value,
    input  logic signed [VAL_W-1:0] i_wanted_value,
    input  logic [WEIGHT_W-1:0]  i_weight,
    input  logic                 i_last_of_entry,
    input  logic                 i_last_of_search,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_elem                o_elem
);

    // Reciprocal of the depth: floor(x * RECIP / 2^32) is exact for 12-bit x
    localparam logic [31:0] RECIP   = 32'(((64'd1 << 32) + 64'(ENTRY_DEPTH) - 64'd1)
                                          / 64'(ENTRY_DEPTH));
    localparam logic [3:0]  KINDS_C = 4'(TAG_KINDS);

    logic [PERIOD_W-1:0] r_period [4];

    logic signed [VAL_W:0]      diff;
    logic signed [PERIOD_W+1:0] wrap;
    logic [DIST_W-1:0]          d0;
    logic [PERIOD_W:0]          d1;
    logic                       contrib;
    logic [43:0]                qprod;

    // Write the period registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period[0] <= PERIOD_RESET;
            r_period[1] <= PERIOD_RESET;
            r_period[2] <= PERIOD_RESET;
            r_period[3] <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_PERIOD_ZERO:  r_period[0] <= i_cfg_data;
                CFG_PERIOD_ONE:   r_period[1] <= i_cfg_data;
                CFG_PERIOD_TWO:   r_period[2] <= i_cfg_data;
                CFG_PERIOD_THREE: r_period[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Plain and wrapped distance, keep the smaller
    always_comb begin
        diff = $signed({i_wanted_value[VAL_W-1], i_wanted_value})
               - $signed({i_stored_value[VAL_W-1], i_stored_value});
        if (!i_wanted_value[VAL_W-1]) begin
            wrap = (PERIOD_W+2)'(diff) - $signed({2'b00, r_period[i_tag_id]});
        end else begin
            wrap = (PERIOD_W+2)'(diff) + $signed({2'b00, r_period[i_tag_id]});
        end
        d0 = diff[VAL_W] ? DIST_W'(-diff) : DIST_W'(diff);
        d1 = wrap[PERIOD_W+1] ? (PERIOD_W+1)'(-wrap) : (PERIOD_W+1)'(wrap);
        contrib = i_tag_present && ({2'b00, i_tag_id} < KINDS_C);
        qprod = {32'b0, i_entry_index} * {12'b0, RECIP};
    end

    // Build the element; a dropped element carries zero weight
    always_comb begin
        o_elem.entry       = i_entry_index;
        o_elem.quot        = qprod[43:32];
        o_elem.min_dist    = (d1 < {9'b0, d0}) ? d1[DIST_W-1:0] : d0;
        o_elem.weight      = contrib ? i_weight : '0;
        o_elem.last_entry  = i_last_of_entry;
        o_elem.last_search = i_last_of_search;
    end

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

endmodule

// File: rtl/wtbm_queue.sv
// ---------------------------------------------------------------------------
// wtbm_queue
// Short first-in first-out queue of classified elements between front and back.
// ---------------------------------------------------------------------------
module wtbm_queue import wtbm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_elem i_elem,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_elem o_elem
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_elem              r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [PTR_W:0]     r_count,  n_count;
    logic               do_pop;

    assign o_full  = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_elem  = r_slot[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + (PTR_W+1)'(i_push) - (PTR_W+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_elem;
        end
    end

endmodule

// File: rtl/wtbm_back.sv
// ---------------------------------------------------------------------------
// wtbm_back
// Weights the distance, reduces the entry index, accumulates the entry total,
// keeps the best entry and holds the search result in an output register.
// ---------------------------------------------------------------------------
module wtbm_back import wtbm_pkg::*; #(
    parameter int ENTRY_DEPTH = ENTRY_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_elem              i_elem,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [IDX_W-1:0]   o_best_index,
    output logic [TOTAL_W-1:0] o_best_total
);

    localparam logic [28:0] DEPTH_C = 29'(ENTRY_DEPTH);

    // Multiply stage
    logic                r_s1_valid;
    logic [PROD_W-1:0]   r_s1_prod;
    logic [IDX_W-1:0]    r_s1_entry;
    logic                r_s1_last_entry;
    logic                r_s1_last_search;

    // Accumulate state
    logic [TOTAL_W-1:0]  r_total,      n_total;
    logic [TOTAL_W-1:0]  r_best,       n_best;
    logic [IDX_W-1:0]    r_best_entry, n_best_entry;
    logic                r_have,       n_have;

    // Output register
    logic                r_out_valid, n_out_valid;
    logic [IDX_W-1:0]    r_out_index;
    logic [TOTAL_W-1:0]  r_out_total;

    logic                s1_done;
    logic                s1_take;
    logic [28:0]         qd;
    logic [IDX_W-1:0]    residue;
    logic [TOTAL_W:0]    sum;
    logic [TOTAL_W-1:0]  total_in;
    logic                win;
    logic [TOTAL_W-1:0]  cand_total;
    logic [IDX_W-1:0]    cand_entry;
    logic                load_out;

    // Stage one moves on unless a search result finds the output register busy
    assign s1_done  = r_s1_valid && (!r_s1_last_search || !r_out_valid || i_out_ready);
    assign s1_take  = !r_s1_valid || s1_done;
    assign o_pop    = s1_take;
    assign load_out = s1_done && r_s1_last_search;

    // Entry index modulo depth from the front's quotient
    always_comb begin
        qd      = {17'b0, i_elem.quot} * DEPTH_C;
        residue = i_elem.entry - qd[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_take) begin
            r_s1_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_take && i_q_valid) begin
            r_s1_prod        <= {32'b0, i_elem.weight} * {32'b0, i_elem.min_dist};
            r_s1_entry       <= residue;
            r_s1_last_entry  <= i_elem.last_entry;
            r_s1_last_search <= i_elem.last_search;
        end
    end

    // Accumulate, close the entry, and close the search
    always_comb begin
        sum      = {1'b0, r_total} + {1'b0, r_s1_prod[PROD_W-1:FRAC_W]};
        total_in = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
        win      = !r_have || (total_in < r_best);
        cand_total = win ? total_in : r_best;
        cand_entry = win ? r_s1_entry : r_best_entry;

        n_total      = r_total;
        n_best       = r_best;
        n_best_entry = r_best_entry;
        n_have       = r_have;
        if (s1_done) begin
            if (r_s1_last_search) begin
                n_total      = '0;
                n_best       = {TOTAL_W{1'b1}};
                n_best_entry = '0;
                n_have       = 1'b0;
            end else if (r_s1_last_entry) begin
                n_total      = '0;
                n_best       = cand_total;
                n_best_entry = cand_entry;
                n_have       = 1'b1;
            end else begin
                n_total = total_in;
            end
        end

        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total      <= '0;
            r_best       <= {TOTAL_W{1'b1}};
            r_best_entry <= '0;
            r_have       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_total      <= n_total;
            r_best       <= n_best;
            r_best_entry <= n_best_entry;
            r_have       <= n_have;
            r_out_valid  <= n_out_valid;
        end
    end

    // Hold the search result
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_index <= cand_entry;
            r_out_total <= cand_total;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_best_index = r_out_index;
    assign o_best_total = r_out_total;

endmodule

// File: rtl/weighted_tag_best_match.sv
// ---------------------------------------------------------------------------
// weighted_tag_best_match
// Takes one tag element per cycle, with no gap between elements or searches,
// while the queue has room: the front forms the smaller of the plain and
// wrapped distance and pushes it into a four-deep queue, the back multiplies
// by the weight in one stage and accumulates in the next, so an add and
// compare loop on the running total sets the rate. The best index and its
// saturated Q32.16 total are loaded into the output register as the element
// that ends the search leaves the multiply stage, and stay there until taken;
// the front keeps accepting meanwhile until the queue fills. Tag periods may
// only be written while no element is in flight.
// ---------------------------------------------------------------------------
module weighted_tag_best_match import wtbm_pkg::*; #(
    parameter int ENTRY_DEPTH = ENTRY_DEPTH_DEF,
    parameter int TAG_KINDS   = TAG_KINDS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [PERIOD_W-1:0]     i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [IDX_W-1:0]        i_entry_index,
    input  logic [TAG_W-1:0]        i_tag_id,
    input  logic                    i_tag_present,
    input  logic signed [VAL_W-1:0] i_stored_value,
    input  logic signed [VAL_W-1:0] i_wanted_value,
    input  logic [WEIGHT_W-1:0]     i_weight,
    input  logic                    i_last_of_entry,
    input  logic                    i_last_of_search,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [IDX_W-1:0]        o_best_index,
    output logic [TOTAL_W-1:0]      o_best_total
);

    logic  q_full;
    logic  push;
    t_elem front_elem;
    logic  pop;
    logic  q_valid;
    t_elem head_elem;

    wtbm_front #(
        .ENTRY_DEPTH (ENTRY_DEPTH),
        .TAG_KINDS   (TAG_KINDS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_entry_index    (i_entry_index),
        .i_tag_id         (i_tag_id),
        .i_tag_present    (i_tag_present),
        .i_stored_value   (i_stored_value),
        .i_wanted_value   (i_wanted_value),
        .i_weight         (i_weight),
        .i_last_of_entry  (i_last_of_entry),
        .i_last_of_search (i_last_of_search),
        .i_q_full         (q_full),
        .o_push           (push),
        .o_elem           (front_elem)
    );

    wtbm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_elem  (front_elem),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_elem  (head_elem)
    );

    wtbm_back #(
        .ENTRY_DEPTH (ENTRY_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_elem       (head_elem),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_best_index (o_best_index),
        .o_best_total (o_best_total)
    );

endmodule

// File: rtl/wtbm_checker.sv
// ---------------------------------------------------------------------------
// wtbm_checker
// Port-level checks of the weighted tag best-match block, bound to the top.
// ---------------------------------------------------------------------------
`include "weighted_tag_best_match_assert.svh"

module wtbm_checker import wtbm_pkg::*; #(
    parameter int ENTRY_DEPTH = ENTRY_DEPTH_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [IDX_W-1:0]   o_best_index,
    input logic [TOTAL_W-1:0] o_best_total
);

    localparam logic [16:0] DEPTH_C = 17'(ENTRY_DEPTH);

    // A stalled result holds its value
    `WTBM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n && o_out_valid && !i_out_ready, o_out_valid && $stable(o_best_index) && $stable(o_best_total))

    // The reported entry lies inside the entry table
    `WTBM_ASSERT_NOW(a_index_range, i_clk, i_rst_n, o_out_valid, {5'b0, o_best_index} < DEPTH_C)

    // Reset drops any pending result
    `WTBM_ASSERT_NEXT(a_reset_clear, i_clk, !i_rst_n, !o_out_valid)

endmodule

bind weighted_tag_best_match wtbm_checker #(
    .ENTRY_DEPTH (ENTRY_DEPTH)
) u_wtbm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_best_index (o_best_index),
    .o_best_total (o_best_total)
);

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for weighted_tag_best_match. An initial block queues tag
// elements (two directed sets, then random searches) and rewrites the four tag
// periods between phases. A clocked driver offers the items over valid/ready.
// A clocked monitor takes the best-match results and checks them against a
// local predictor of the weighted distance totals.
// ----------------------------------------------------------------------------
module tb;
    import wtbm_pkg::*;

    localparam int          SETTLE_CYCLES  = 16;
    localparam int          RX_HOLD_CYCLES = 400;
    localparam int unsigned CYCLE_LIMIT    = 200000;

    typedef struct {
        logic [IDX_W-1:0]    entry;
        logic [TAG_W-1:0]    tag;
        logic                present;
        logic [VAL_W-1:0]    stored;
        logic [VAL_W-1:0]    wanted;
        logic [WEIGHT_W-1:0] weight;
        logic                end_entry;
        logic                end_search;
    } tag_elem_t;

    typedef struct {
        logic [IDX_W-1:0]   index;
        logic [TOTAL_W-1:0] total;
    } best_match_t;

    // Block ports
    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_cfg_we         = 1'b0;
    t_cfg_reg            i_cfg_index      = CFG_PERIOD_ZERO;
    logic [PERIOD_W-1:0] i_cfg_data       = '0;
    logic                i_in_valid       = 1'b0;
    logic                o_in_ready;
    logic [IDX_W-1:0]    i_entry_index    = '0;
    logic [TAG_W-1:0]    i_tag_id         = '0;
    logic                i_tag_present    = 1'b0;
    logic [VAL_W-1:0]    i_stored_value   = '0;
    logic [VAL_W-1:0]    i_wanted_value   = '0;
    logic [WEIGHT_W-1:0] i_weight         = '0;
    logic                i_last_of_entry  = 1'b0;
    logic                i_last_of_search = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready      = 1'b0;
    logic [IDX_W-1:0]    o_best_index;
    logic [TOTAL_W-1:0]  o_best_total;

    // Predictor state
    logic [PERIOD_W-1:0] tag_period_q [4] = '{default: PERIOD_RESET};
    logic [TOTAL_W-1:0]  run_total        = '0;
    logic [TOTAL_W-1:0]  best_total       = '1;
    logic [IDX_W-1:0]    best_entry       = '0;
    logic                have_best        = 1'b0;

    // Traffic bookkeeping
    tag_elem_t   pend_elems [$];
    tag_elem_t   cur_elem;
    best_match_t best_due [$];
    int          items_queued   = 0;
    int          items_taken    = 0;
    int          mismatch_cnt   = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int unsigned cycle_cnt      = 0;
    logic        hold_trig      = 1'b0;
    logic        hold_seen      = 1'b0;
    int          hold_left      = 0;

    weighted_tag_best_match dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_entry_index    (i_entry_index),
        .i_tag_id         (i_tag_id),
        .i_tag_present    (i_tag_present),
        .i_stored_value   (i_stored_value),
        .i_wanted_value   (i_wanted_value),
        .i_weight         (i_weight),
        .i_last_of_entry  (i_last_of_entry),
        .i_last_of_search (i_last_of_search),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_best_index     (o_best_index),
        .o_best_total     (o_best_total)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [63:0] mag(logic signed [63:0] v);
        return v[63] ? -v : v;
    endfunction

    // Weighted distance of one element, the nearer of plain and wrapped
    function automatic logic [TOTAL_W-1:0] elem_cost(tag_elem_t e);
        logic signed [63:0] want_v;
        logic signed [63:0] have_v;
        logic signed [63:0] per;
        logic signed [63:0] moved;
        logic [63:0]        d_plain;
        logic [63:0]        d_wrap;
        logic [63:0]        prod;
        want_v  = $signed({{32{e.wanted[VAL_W-1]}}, e.wanted});
        have_v  = $signed({{32{e.stored[VAL_W-1]}}, e.stored});
        per     = $signed({24'd0, tag_period_q[e.tag]});
        // zero wanted counts as positive
        moved   = want_v[63] ? want_v + per : want_v - per;
        d_plain = mag(want_v - have_v);
        d_wrap  = mag(moved - have_v);
        prod    = {32'd0, e.weight} * (d_plain < d_wrap ? d_plain : d_wrap);
        // product stays below 2^64, so the Q32.16 term always fits in 48 bits
        return prod[63:FRAC_W];
    endfunction

    // Accumulate one accepted element; close entries and searches
    function automatic void fold_element(tag_elem_t e);
        logic [TOTAL_W:0] sum;
        best_match_t      res;
        // 12-bit index modulo 4096 entries is the index itself; all four
        // tag kinds are in use, so every present element counts
        if (e.present) begin
            sum       = {1'b0, run_total} + {1'b0, elem_cost(e)};
            run_total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
        end
        if (e.end_entry || e.end_search) begin
            if (!have_best || run_total < best_total) begin
                best_total = run_total;
                best_entry = e.entry;
                have_best  = 1'b1;
            end
            run_total = '0;
        end
        if (e.end_search) begin
            res.index  = best_entry;
            res.total  = best_total;
            best_due.push_back(res);
            best_total = '1;
            best_entry = '0;
            have_best  = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer pending items, fold accepted ones into the predictor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                fold_element(cur_elem);
                items_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pend_elems.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_elem          = pend_elems.pop_front();
                    i_in_valid       <= 1'b1;
                    i_entry_index    <= cur_elem.entry;
                    i_tag_id         <= cur_elem.tag;
                    i_tag_present    <= cur_elem.present;
                    i_stored_value   <= cur_elem.stored;
                    i_wanted_value   <= cur_elem.wanted;
                    i_weight         <= cur_elem.weight;
                    i_last_of_entry  <= cur_elem.end_entry;
                    i_last_of_search <= cur_elem.end_search;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver hold-off counter
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_trig != hold_seen) begin
            hold_seen <= hold_trig;
            hold_left <= RX_HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each taken result against the oldest expected one
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        best_match_t due;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (best_due.size() == 0) begin
                if (mismatch_cnt < 10)
                    $display("unexpected result: best_index %0d best_total %h",
                             o_best_index, o_best_total);
                mismatch_cnt++;
            end else begin
                due = best_due.pop_front();
                if (o_best_index !== due.index || o_best_total !== due.total) begin
                    if (mismatch_cnt < 10)
                        $display("mismatch: best_index exp %0d got %0d, best_total exp %h got %h",
                                 due.index, o_best_index, due.total, o_best_total);
                    mismatch_cnt++;
                end
            end
        end
        i_out_ready <= i_rst_n && hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic tag_elem_t make_elem(logic [IDX_W-1:0] entry, logic [TAG_W-1:0] tag,
                                            logic present, logic [VAL_W-1:0] stored,
                                            logic [VAL_W-1:0] wanted,
                                            logic [WEIGHT_W-1:0] weight,
                                            logic end_entry, logic end_search);
        tag_elem_t e;
        e.entry      = entry;
        e.tag        = tag;
        e.present    = present;
        e.stored     = stored;
        e.wanted     = wanted;
        e.weight     = weight;
        e.end_entry  = end_entry;
        e.end_search = end_search;
        return e;
    endfunction

    function automatic void push_elem(tag_elem_t e);
        pend_elems.push_back(e);
        items_queued++;
    endfunction

    // Signed Q16.16 value biased toward the extremes
    function automatic logic [VAL_W-1:0] rand_q16();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0001_0000;
            3: return $urandom_range(0, 32'h0004_0000);
            default: return $urandom();
        endcase
    endfunction

    // Period mostly near the value span, so wrapping actually wins
    function automatic logic [PERIOD_W-1:0] rand_period();
        logic [PERIOD_W-1:0] p;
        case ($urandom_range(0, 5))
            0: p = '0;
            1: p = '1;
            2: p = PERIOD_RESET;
            3: p = {8'($urandom()), 32'($urandom())};
            default: begin
                p = {8'd0, 32'($urandom())};
                if ($urandom_range(0, 1) != 0)
                    p = p + 40'h01_0000_0000;
            end
        endcase
        return p;
    endfunction

    function automatic tag_elem_t rand_elem();
        tag_elem_t e;
        e.entry      = IDX_W'($urandom());
        e.tag        = TAG_W'($urandom());
        e.present    = ($urandom_range(0, 9) != 0);
        e.stored     = rand_q16();
        e.wanted     = rand_q16();
        e.weight     = rand_weight();
        e.end_entry  = 1'b0;
        e.end_search = 1'b0;
        return e;
    endfunction

    // Queue one well-formed search; repeat an entry now and then for ties
    task automatic queue_search(input bit short_form);
        int               n_ent;
        int               n_el;
        tag_elem_t        e;
        tag_elem_t        prev_ent [$];
        tag_elem_t        this_ent [$];
        logic [IDX_W-1:0] idx;
        n_ent = short_form ? $urandom_range(1, 2) : $urandom_range(1, 6);
        for (int i = 0; i < n_ent; i++) begin
            idx = IDX_W'($urandom());
            this_ent.delete();
            if (prev_ent.size() != 0 && $urandom_range(0, 4) == 0) begin
                this_ent = prev_ent;
            end else begin
                n_el = short_form ? 1 : $urandom_range(1, 4);
                repeat (n_el) this_ent.push_back(rand_elem());
            end
            prev_ent = this_ent;
            foreach (this_ent[k]) begin
                e            = this_ent[k];
                e.entry      = idx;
                e.end_entry  = (k == this_ent.size() - 1);
                e.end_search = 1'b0;
                if (i == n_ent - 1 && k == this_ent.size() - 1) begin
                    e.end_search = 1'b1;
                    // let the search end close the entry by itself
                    if ($urandom_range(0, 4) == 0)
                        e.end_entry = 1'b0;
                end
                push_elem(e);
            end
        end
    endtask

    // Wait for every item and result, then let the pipeline drain
    task automatic settle();
        while (items_taken != items_queued) @(posedge i_clk);
        while (best_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all four tag periods in order; block is idle
    task automatic write_periods(input logic [PERIOD_W-1:0] p0, p1, p2, p3);
        logic [PERIOD_W-1:0] vals [4];
        t_cfg_reg            sel;
        vals = '{p0, p1, p2, p3};
        sel  = sel.first();
        repeat (4) begin
            @(posedge i_clk);
            i_cfg_we          <= 1'b1;
            i_cfg_index       <= sel;
            i_cfg_data        <= vals[sel];
            tag_period_q[sel]  = vals[sel];
            sel                = sel.next();
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random phase: mostly well-formed searches, some loose elements
    task automatic run_phase(input int n_items, input int s_pct, input int r_pct,
                             input bit short_form, input bit hold_rx);
        int        start;
        tag_elem_t e;
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        start          = items_queued;
        while (items_queued - start < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                e            = rand_elem();
                e.end_entry  = ($urandom_range(0, 3) == 0);
                e.end_search = ($urandom_range(0, 15) == 0);
                push_elem(e);
            end else begin
                queue_search(short_form);
            end
        end
        // stall the output long enough for the input to back up
        if (hold_rx) begin
            @(posedge i_clk);
            hold_trig <= ~hold_trig;
        end
        settle();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset periods: saturation, first entry wins, absent tag,
        // ties, search end without entry end, zero and negative wanted
        push_elem(make_elem(12'd0, 2'd0, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'hFFFF_FFFF, 1'b1, 1'b1));
        push_elem(make_elem(12'd4095, 2'd1, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'hFFFF_FFFF, 1'b0, 1'b0));
        push_elem(make_elem(12'd4095, 2'd1, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'hFFFF_FFFF, 1'b1, 1'b1));
        push_elem(make_elem(12'd7, 2'd2, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'hFFFF_FFFF, 1'b1, 1'b0));
        push_elem(make_elem(12'd9, 2'd3, 1'b1, 32'h0000_0000, 32'h0001_0000,
                            32'h0001_0000, 1'b1, 1'b1));
        push_elem(make_elem(12'd3, 2'd0, 1'b1, 32'h0000_0000, 32'h0002_0000,
                            32'h0001_0000, 1'b1, 1'b0));
        push_elem(make_elem(12'd5, 2'd0, 1'b1, 32'h0000_0000, 32'h0002_0000,
                            32'h0001_0000, 1'b1, 1'b0));
        push_elem(make_elem(12'd6, 2'd1, 1'b1, 32'h0000_0000, 32'h0002_0000,
                            32'h0003_0000, 1'b0, 1'b1));
        push_elem(make_elem(12'd10, 2'd1, 1'b1, 32'hFFFB_0000, 32'h0000_0000,
                            32'h0001_0000, 1'b1, 1'b0));
        push_elem(make_elem(12'd11, 2'd2, 1'b1, 32'h0064_0000, 32'hFFFF_FFFF,
                            32'h0000_8000, 1'b0, 1'b1));
        push_elem(make_elem(12'd4095, 2'd3, 1'b1, 32'h0000_0001, 32'hFFFF_FFFF,
                            32'h0000_0001, 1'b1, 1'b1));
        settle();

        // Directed, wrapping: period 65536.0, zero, full scale, 49152.0
        write_periods(40'h01_0000_0000, 40'h00_0000_0000, 40'hFF_FFFF_FFFF,
                      40'h00_C000_0000);
        push_elem(make_elem(12'd1, 2'd0, 1'b1, 32'h8001_0000, 32'h7FFF_0000,
                            32'h0001_0000, 1'b1, 1'b0));
        push_elem(make_elem(12'd2, 2'd1, 1'b1, 32'h1234_5678, 32'h8765_4321,
                            32'h0001_0000, 1'b1, 1'b0));
        push_elem(make_elem(12'd4, 2'd2, 1'b1, 32'h0000_0000, 32'h8000_0000,
                            32'hFFFF_FFFF, 1'b1, 1'b1));
        push_elem(make_elem(12'd8, 2'd3, 1'b1, 32'h8000_0000, 32'h0000_0000,
                            32'hFFFF_FFFF, 1'b1, 1'b1));
        push_elem(make_elem(12'd12, 2'd0, 1'b1, 32'h7FFF_0000, 32'h8001_0000,
                            32'h0002_0000, 1'b0, 1'b0));
        push_elem(make_elem(12'd13, 2'd3, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'hFFFF_FFFF, 1'b0, 1'b0));
        push_elem(make_elem(12'd14, 2'd2, 1'b1, 32'h0010_0000, 32'hFFF0_0000,
                            32'h0000_4000, 1'b1, 1'b1));
        settle();

        // Random phases, new periods before each
        write_periods(40'hFF_FFFF_FFFF, 40'h00_0000_0000, PERIOD_RESET, rand_period());
        run_phase(400, 0, 0, 1'b0, 1'b0);
        write_periods(rand_period(), rand_period(), rand_period(), rand_period());
        run_phase(400, 55, 0, 1'b0, 1'b0);
        write_periods(rand_period(), rand_period(), rand_period(), rand_period());
        run_phase(400, 0, 55, 1'b0, 1'b0);
        write_periods(rand_period(), rand_period(), rand_period(), rand_period());
        run_phase(400, 36, 36, 1'b0, 1'b0);
        write_periods(rand_period(), rand_period(), rand_period(), rand_period());
        run_phase(400, 0, 0, 1'b1, 1'b1);

        if (mismatch_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: weighted_tag_best_match.f
+incdir+rtl
rtl/wtbm_pkg.sv
rtl/wtbm_front.sv
rtl/wtbm_queue.sv
rtl/wtbm_back.sv
rtl/weighted_tag_best_match.sv
rtl/wtbm_checker.sv
tb/sv/tb.sv
